### hdl/kml_pkg.sv
`default_nettype none

package kml_pkg;

    // Keyword window size and field widths
    localparam int KML_MAX_PATTERN = 8;
    localparam int KML_ROW_W       = 24;
    localparam int KML_COL_W       = 16;
    localparam int KML_QDEPTH      = 2;

    localparam logic [7:0]           KML_NEWLINE = 8'h0A;
    localparam logic [KML_ROW_W-1:0] KML_ROW_MAX = {KML_ROW_W{1'b1}};
    localparam logic [KML_COL_W-1:0] KML_COL_MAX = {KML_COL_W{1'b1}};

    // Register indexes on the configuration port (8-byte spacing)
    typedef enum logic {
        KML_REG_PATTERN = 1'b0,
        KML_REG_LENGTH  = 1'b1
    } t_kml_reg;

    // One classified text item handed from the front to the scanner
    typedef struct packed {
        logic [7:0]           text_byte;
        logic                 newline;
        logic                 end_of_file;
        logic [KML_ROW_W-1:0] row;
        logic [KML_COL_W-1:0] column;
    } t_kml_item;

endpackage

`default_nettype wire

### hdl/kml_front.sv
`default_nettype none

module kml_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  wire [7:0]               i_text_byte,
    input  wire                     i_end_of_file,
    output kml_pkg::t_kml_item      o_item
);
    import kml_pkg::*;

    logic [KML_ROW_W-1:0] r_row;
    logic [KML_COL_W-1:0] r_col;
    logic [KML_ROW_W-1:0] n_row;
    logic [KML_COL_W-1:0] n_col;
    logic                 w_newline;

    // Position of the incoming byte: newline bumps the row, others the column
    assign w_newline = (i_text_byte == KML_NEWLINE);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_newline) begin
            if (r_row != KML_ROW_MAX) begin
                n_row = r_row + KML_ROW_W'(1);
            end
            n_col = '0;
        end else if (r_col != KML_COL_MAX) begin
            n_col = r_col + KML_COL_W'(1);
        end
    end

    assign o_item.text_byte   = i_text_byte;
    assign o_item.newline     = w_newline;
    assign o_item.end_of_file = i_end_of_file;
    assign o_item.row         = n_row;
    assign o_item.column      = n_col;

    // Counters restart after the last byte of a file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= KML_ROW_W'(1);
            r_col <= '0;
        end else if (i_accept) begin
            if (i_end_of_file) begin
                r_row <= KML_ROW_W'(1);
                r_col <= '0;
            end else begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/kml_queue.sv
`default_nettype none

module kml_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire kml_pkg::t_kml_item i_item,
    input  wire                     i_pop,
    output kml_pkg::t_kml_item      o_item,
    output logic                    o_valid,
    output logic                    o_full
);
    import kml_pkg::*;

    localparam int PW = (KML_QDEPTH > 1) ? $clog2(KML_QDEPTH) : 1;
    localparam int CW = $clog2(KML_QDEPTH + 1);

    t_kml_item      r_mem [KML_QDEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == CW'(KML_QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(KML_QDEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(KML_QDEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/kml_scan.sv
`default_nettype none

module kml_scan #(
    parameter int MAX_PATTERN = kml_pkg::KML_MAX_PATTERN
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [63:0]                      i_pattern_bytes,
    input  wire  [3:0]                       i_pattern_length,
    input  wire kml_pkg::t_kml_item          i_item,
    input  wire                              i_item_valid,
    output logic                             o_pop,
    input  wire                              i_out_stall,
    output logic                             o_out_valid,
    output logic [kml_pkg::KML_ROW_W-1:0]    o_match_row,
    output logic [kml_pkg::KML_COL_W-1:0]    o_match_column
);
    import kml_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    // Sliding window, newest byte at index 0
    logic [7:0]           r_win     [MAX_PATTERN];
    logic                 r_nl      [MAX_PATTERN];
    logic [KML_ROW_W-1:0] r_row     [MAX_PATTERN];
    logic [KML_COL_W-1:0] r_col     [MAX_PATTERN];
    logic [LW-1:0]        r_cnt;

    logic [7:0]           n_win     [MAX_PATTERN];
    logic                 n_nl      [MAX_PATTERN];
    logic [KML_ROW_W-1:0] n_row     [MAX_PATTERN];
    logic [KML_COL_W-1:0] n_col     [MAX_PATTERN];
    logic [LW-1:0]        n_cnt;

    logic                 r_out_valid;
    logic [KML_ROW_W-1:0] r_out_row;
    logic [KML_COL_W-1:0] r_out_col;

    logic [LW-1:0]        w_len;
    logic [IW-1:0]        w_start;
    logic [2:0]           w_pidx;
    logic                 w_hit;

    // Clamp the keyword length to the window size
    assign w_len = (i_pattern_length > 4'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                        : LW'(i_pattern_length);
    assign w_start = IW'(int'(w_len) - 1);

    assign o_pop = i_item_valid && (!r_out_valid || !i_out_stall);

    // Shifted window as it stands once the new byte is in
    always_comb begin
        n_win[0] = i_item.text_byte;
        n_nl[0]  = i_item.newline;
        n_row[0] = i_item.row;
        n_col[0] = i_item.column;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
            n_nl[j]  = r_nl[j-1];
            n_row[j] = r_row[j-1];
            n_col[j] = r_col[j-1];
        end
        n_cnt = (r_cnt == LW'(MAX_PATTERN)) ? r_cnt : r_cnt + LW'(1);
    end

    // Parallel compare: window entry j holds keyword byte len-1-j
    always_comb begin
        w_pidx = '0;
        w_hit  = (w_len != '0) && (n_cnt >= w_len) && !n_nl[w_start];
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_pidx = 3'(int'(w_len) - 1 - j);
            if (j < int'(w_len)) begin
                if (n_win[j] != i_pattern_bytes[8*w_pidx +: 8]) begin
                    w_hit = 1'b0;
                end
            end
        end
    end

    // Window contents
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= n_win[j];
                r_nl[j]  <= n_nl[j];
                r_row[j] <= n_row[j];
                r_col[j] <= n_col[j];
            end
        end
    end

    // Fill count; a file end empties the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_pop) begin
            r_cnt <= i_item.end_of_file ? '0 : n_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= w_hit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_hit) begin
            r_out_row <= n_row[w_start];
            r_out_col <= n_col[w_start];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_match_row    = r_out_row;
    assign o_match_column = r_out_col;

endmodule

`default_nettype wire

### hdl/keyword_match_locator_unit.sv
`default_nettype none

// Keyword match locator: scans text one byte per item for a keyword of 1 to
// MAX_PATTERN bytes (set through pattern_bytes at 0x0 and pattern_length at
// 0x8) and reports the row and column of the first byte of every match that
// does not start on a newline, overlapping matches included, counted from 1
// and saturating. The block takes one item per clock while its queue is not
// full. A match shows on the outputs once the byte that completes it has
// passed through the two-entry queue behind the row/column front and the
// window compare on the queue head has loaded the output register. The queue
// absorbs output stalls, so input stall rises only after two items back up
// behind a stalled result. A byte flagged end_of_file restarts the counters
// and the window after it is scanned.
module keyword_match_locator_unit #(
    parameter int MAX_PATTERN = kml_pkg::KML_MAX_PATTERN
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Text input channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [7:0]                       i_text_byte,
    input  wire                              i_end_of_file,
    // Match output channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [kml_pkg::KML_ROW_W-1:0]    o_match_row,
    output logic [kml_pkg::KML_COL_W-1:0]    o_match_column,
    // Configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [3:0]                       paddr,
    input  wire  [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);
    import kml_pkg::*;

    logic [63:0] r_pattern_bytes;
    logic [3:0]  r_pattern_length;
    logic        w_cfg_wr;
    t_kml_reg    w_reg;

    logic        w_in_accept;
    t_kml_item   w_front_item;
    t_kml_item   w_q_item;
    logic        w_q_valid;
    logic        w_q_full;
    logic        w_q_pop;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_kml_reg'(paddr[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= 4'd1;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                KML_REG_PATTERN: r_pattern_bytes  <= pwdata;
                KML_REG_LENGTH:  r_pattern_length <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            KML_REG_PATTERN: prdata = r_pattern_bytes;
            KML_REG_LENGTH:  prdata = {60'd0, r_pattern_length};
            default:         prdata = '0;
        endcase
    end

    // Front: position tracking and classification
    assign o_in_stall  = w_q_full;
    assign w_in_accept = i_in_valid && !w_q_full;

    kml_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_text_byte   (i_text_byte),
        .i_end_of_file (i_end_of_file),
        .o_item        (w_front_item)
    );

    // Decoupling queue
    kml_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_accept),
        .i_item  (w_front_item),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    // Back: window compare and result register
    kml_scan #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pattern_bytes  (r_pattern_bytes),
        .i_pattern_length (r_pattern_length),
        .i_item           (w_q_item),
        .i_item_valid     (w_q_valid),
        .o_pop            (w_q_pop),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_match_row      (o_match_row),
        .o_match_column   (o_match_column)
    );

    // An accepted item is in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> w_q_valid)
        else $error("accepted item missing from queue");

    // A new result only follows a queue pop
    a_result_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_q_pop))
        else $error("result appeared without a scanned item");

    // A match never starts on a newline, so its position is never zero
    a_position_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_match_row != '0) && (o_match_column != '0))
        else $error("match position out of range");

endmodule

`default_nettype wire
